/* rtl/core/icb_pkg.sv */
// Shared types and codes for the insertable character buffer.
package icb_pkg;

   localparam int CAPACITY_DEFAULT = 128;

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic [1:0] CMD_HOLD   = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_INSERT = 2'd2;
   localparam logic [1:0] CMD_DELETE = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [6:0] position;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic [7:0] length;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] position;
      logic [7:0] character;
   } cmd_type;

endpackage

/* rtl/core/icb_cell.sv */
// One buffer entry that shifts to or from its neighbors on insert and delete.
module icb_cell #(
   parameter int INDEX = 0,
   parameter int W     = 8
) (
   input  logic            clock,
   input  icb_pkg::cmd_type cmd,
   input  logic [W-1:0]    count,
   input  logic [7:0]      left_data,
   input  logic [7:0]      right_data,
   output logic [7:0]      data,
   output logic [7:0]      read_data
);

   localparam logic [W-1:0] IDX = W'(INDEX);

   logic [7:0]   data_ff;
   logic [7:0]   data_in;
   logic [W-1:0] pos;

   assign pos = W'(cmd.position);

   always_comb begin
      data_in = data_ff;
      unique case (cmd.kind)
         icb_pkg::CMD_APPEND: begin
            if (IDX == count) data_in = cmd.character;
         end
         icb_pkg::CMD_INSERT: begin
            if (IDX == pos) data_in = cmd.character;
            else if (IDX > pos) data_in = left_data;
         end
         icb_pkg::CMD_DELETE: begin
            if (IDX >= pos) data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign read_data = (IDX == pos) ? data_ff : 8'h00;

endmodule

/* rtl/core/insertable_char_buffer.sv */
// Top level of the insertable character buffer: decode, cell row and result register.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | icb_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready | icb_pkg::rsp_type
//
// Every operation completes in the cycle it is accepted; the result is registered and
// shows in the cycle after. One transaction per cycle is sustained while rsp_ready is high.
// The whole cell row shifts in parallel; insert and delete are no slower than append or read.
// Reset clears the length and the result valid; cell contents are undefined until written.
// A stalled result holds the input off until it is taken.
module insertable_char_buffer #(
   parameter int CAPACITY = icb_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  icb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output icb_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int W     = (CNT_W > 8) ? CNT_W : 8;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   icb_pkg::rsp_type rsp_payload_ff;
   icb_pkg::rsp_type rsp_payload_in;

   icb_pkg::cmd_type cmd;
   logic             accept;
   logic             full;
   logic [W-1:0]     pos_w;
   logic [W-1:0]     count_w;
   logic [1:0]       status;
   logic [1:0]       kind;
   logic [7:0]       read_char;
   logic [7:0]       read_bus;

   logic [7:0] cell_data [CAPACITY];
   logic [7:0] cell_read [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pos_w     = W'(req_payload.position);
   assign count_w   = W'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      read_bus = 8'h00;
      for (int i = 0; i < CAPACITY; i++) begin
         read_bus = read_bus | cell_read[i];
      end
   end

   always_comb begin
      status    = icb_pkg::STATUS_OK;
      kind      = icb_pkg::CMD_HOLD;
      read_char = 8'h00;
      unique case (req_payload.func)
         icb_pkg::FUNC_APPEND: begin
            if (full) status = icb_pkg::STATUS_FULL;
            else kind = icb_pkg::CMD_APPEND;
         end
         icb_pkg::FUNC_INSERT: begin
            if (full) status = icb_pkg::STATUS_FULL;
            else if (pos_w > count_w) status = icb_pkg::STATUS_RANGE;
            else kind = icb_pkg::CMD_INSERT;
         end
         icb_pkg::FUNC_DELETE: begin
            if (pos_w >= count_w) status = icb_pkg::STATUS_RANGE;
            else kind = icb_pkg::CMD_DELETE;
         end
         default: begin
            if (pos_w >= count_w) status = icb_pkg::STATUS_RANGE;
            else read_char = read_bus;
         end
      endcase
   end

   always_comb begin
      cmd.kind      = accept ? kind : icb_pkg::CMD_HOLD;
      cmd.position  = req_payload.position;
      cmd.character = req_payload.character;
   end

   always_comb begin
      count_in = count_ff;
      unique case (cmd.kind) inside
         icb_pkg::CMD_APPEND, icb_pkg::CMD_INSERT: count_in = count_ff + CNT_W'(1);
         icb_pkg::CMD_DELETE:                      count_in = count_ff - CNT_W'(1);
         default:                                  count_in = count_ff;
      endcase
   end

   logic [W-1:0] length_w;
   assign length_w = W'(count_in);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.read_char = read_char;
         rsp_payload_in.length    = length_w[7:0];
         rsp_payload_in.status    = status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [7:0] left_data;
      logic [7:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = 8'h00;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      icb_cell #(
         .INDEX(i),
         .W    (W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_w),
         .left_data (left_data),
         .right_data(right_data),
         .data      (cell_data[i]),
         .read_data (cell_read[i])
      );
   end

endmodule
